// ===== rtl/core/cone_support_point_macros.svh =====
// Assertion macros shared by the cone support point RTL.
`ifndef CONE_SUPPORT_POINT_MACROS_SVH
`define CONE_SUPPORT_POINT_MACROS_SVH
`ifndef ASSERT_OFF
`define CSP_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define CSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define CSP_ASSERT_NOW(lbl, cond, msg)
`define CSP_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/csp_pkg.sv =====
// Types and constants shared by the cone support point modules.
package csp_pkg;

  localparam int CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM_RADIUS  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_QUARTER_HEIGHT = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SIN_ANGLE      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EPSILON        = 8'd3;

  localparam logic [28:0] RESET_BOTTOM_RADIUS  = 29'd65536;
  localparam logic [28:0] RESET_QUARTER_HEIGHT = 29'd16384;
  localparam logic [16:0] RESET_SIN_ANGLE      = 17'd46341;
  localparam logic [15:0] RESET_EPSILON        = 16'd1;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } vec_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] y;
    logic [59:0]        num_x;
    logic [59:0]        num_z;
    logic               neg_x;
    logic               neg_z;
  } csp_side_t;

  typedef struct packed {
    logic nz;
    logic apex;
    logic sok;
    logic ovx;
    logic ovz;
    logic neg_x;
    logic neg_z;
  } csp_flags_t;

endpackage

// ===== rtl/core/csp_sqrt_pipe.sv =====
// Pipelined dual-lane integer square root, one result bit per stage.
module csp_sqrt_pipe import csp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] n_norm,
  input  logic [63:0] n_axis,
  input  csp_side_t   side_in,
  output logic        out_valid,
  output logic [31:0] norm,
  output logic [31:0] axis,
  output csp_side_t   side_out
);

  localparam int NSTEP = 32;

  function automatic logic [65:0] sqrt_step(input logic [33:0] rem, input logic [31:0] root,
                                            input logic [1:0] pair);
    logic [35:0] r2;
    logic [35:0] trial;
    logic [35:0] diff;
    r2 = {rem, pair};
    trial = {2'b00, root, 2'b01};
    diff = r2 - trial;
    if (r2 >= trial) begin
      sqrt_step = {diff[33:0], root[30:0], 1'b1};
    end else begin
      sqrt_step = {r2[33:0], root[30:0], 1'b0};
    end
  endfunction

  logic        v_q  [NSTEP];
  logic [33:0] rn_q [NSTEP];
  logic [33:0] ra_q [NSTEP];
  logic [31:0] qn_q [NSTEP];
  logic [31:0] qa_q [NSTEP];
  logic [63:0] nn_q [NSTEP];
  logic [63:0] na_q [NSTEP];
  csp_side_t   sd_q [NSTEP];

  genvar k;
  generate
    for (k = 0; k < NSTEP; k++) begin : g_step
      logic        v_p;
      logic [33:0] rn_p;
      logic [33:0] ra_p;
      logic [31:0] qn_p;
      logic [31:0] qa_p;
      logic [63:0] nn_p;
      logic [63:0] na_p;
      csp_side_t   sd_p;
      logic [65:0] stn;
      logic [65:0] sta;
      if (k == 0) begin : g_first
        assign v_p  = in_valid;
        assign rn_p = '0;
        assign ra_p = '0;
        assign qn_p = '0;
        assign qa_p = '0;
        assign nn_p = n_norm;
        assign na_p = n_axis;
        assign sd_p = side_in;
      end else begin : g_next
        assign v_p  = v_q[k-1];
        assign rn_p = rn_q[k-1];
        assign ra_p = ra_q[k-1];
        assign qn_p = qn_q[k-1];
        assign qa_p = qa_q[k-1];
        assign nn_p = nn_q[k-1];
        assign na_p = na_q[k-1];
        assign sd_p = sd_q[k-1];
      end
      assign stn = sqrt_step(rn_p, qn_p, nn_p[63:62]);
      assign sta = sqrt_step(ra_p, qa_p, na_p[63:62]);
      always_ff @(posedge clk) begin
        if (rst) begin
          v_q[k] <= 1'b0;
        end else if (en) begin
          v_q[k] <= v_p;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rn_q[k] <= stn[65:32];
          qn_q[k] <= stn[31:0];
          ra_q[k] <= sta[65:32];
          qa_q[k] <= sta[31:0];
          nn_q[k] <= {nn_p[61:0], 2'b00};
          na_q[k] <= {na_p[61:0], 2'b00};
          sd_q[k] <= sd_p;
        end
      end
    end
  endgenerate

  assign out_valid = v_q[NSTEP-1];
  assign norm      = qn_q[NSTEP-1];
  assign axis      = qa_q[NSTEP-1];
  assign side_out  = sd_q[NSTEP-1];

endmodule

// ===== rtl/core/csp_div_pipe.sv =====
// Pipelined dual-lane restoring divider, one quotient bit per stage.
module csp_div_pipe import csp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] s,
  input  logic [59:0] num_x,
  input  logic [59:0] num_z,
  input  csp_flags_t  flags_in,
  output logic        out_valid,
  output logic [30:0] quo_x,
  output logic [30:0] quo_z,
  output csp_flags_t  flags_out
);

  localparam int NSTEP = 31;

  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic [31:0] d,
                                           input logic b);
    logic [32:0] r2;
    logic [32:0] diff;
    r2 = {rem, b};
    diff = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      div_step = {1'b1, diff[31:0]};
    end else begin
      div_step = {1'b0, r2[31:0]};
    end
  endfunction

  logic        v_q  [NSTEP];
  logic [31:0] d_q  [NSTEP];
  logic [31:0] rx_q [NSTEP];
  logic [31:0] rz_q [NSTEP];
  logic [30:0] lx_q [NSTEP];
  logic [30:0] lz_q [NSTEP];
  logic [30:0] qx_q [NSTEP];
  logic [30:0] qz_q [NSTEP];
  csp_flags_t  f_q  [NSTEP];

  genvar k;
  generate
    for (k = 0; k < NSTEP; k++) begin : g_step
      logic        v_p;
      logic [31:0] d_p;
      logic [31:0] rx_p;
      logic [31:0] rz_p;
      logic [30:0] lx_p;
      logic [30:0] lz_p;
      logic [30:0] qx_p;
      logic [30:0] qz_p;
      csp_flags_t  f_p;
      logic [32:0] stx;
      logic [32:0] stz;
      if (k == 0) begin : g_first
        assign v_p  = in_valid;
        assign d_p  = s;
        assign rx_p = {3'b000, num_x[59:31]};
        assign rz_p = {3'b000, num_z[59:31]};
        assign lx_p = num_x[30:0];
        assign lz_p = num_z[30:0];
        assign qx_p = '0;
        assign qz_p = '0;
        assign f_p  = flags_in;
      end else begin : g_next
        assign v_p  = v_q[k-1];
        assign d_p  = d_q[k-1];
        assign rx_p = rx_q[k-1];
        assign rz_p = rz_q[k-1];
        assign lx_p = lx_q[k-1];
        assign lz_p = lz_q[k-1];
        assign qx_p = qx_q[k-1];
        assign qz_p = qz_q[k-1];
        assign f_p  = f_q[k-1];
      end
      assign stx = div_step(rx_p, d_p, lx_p[30]);
      assign stz = div_step(rz_p, d_p, lz_p[30]);
      always_ff @(posedge clk) begin
        if (rst) begin
          v_q[k] <= 1'b0;
        end else if (en) begin
          v_q[k] <= v_p;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          d_q[k]  <= d_p;
          rx_q[k] <= stx[31:0];
          rz_q[k] <= stz[31:0];
          lx_q[k] <= {lx_p[29:0], 1'b0};
          lz_q[k] <= {lz_p[29:0], 1'b0};
          qx_q[k] <= {qx_p[29:0], stx[32]};
          qz_q[k] <= {qz_p[29:0], stz[32]};
          f_q[k]  <= f_p;
        end
      end
    end
  endgenerate

  assign out_valid = v_q[NSTEP-1];
  assign quo_x     = qx_q[NSTEP-1];
  assign quo_z     = qz_q[NSTEP-1];
  assign flags_out = f_q[NSTEP-1];

endmodule

// ===== rtl/core/cone_support_point.sv =====
// Cone support mapping: direction vector in, farthest cone surface point out.
//
// Requests arrive on in_valid/in_ready with a vec_t payload of signed Q16.16
// components; results leave on out_valid/out_ready as a point_t. Registers are
// written through cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high and indexes above 3 are ignored. Write them only while no
// request is in flight.
// One request can enter every cycle while the output is not stalled. Besides the
// 32 square root stages and 31 quotient stages, one bit each, a request is held
// in the input, square, sum, cone test, flag and output registers.
// All stages advance together whenever the output register is empty or being
// taken, so a stalled receiver holds the whole pipeline and drops in_ready.
// Synchronous reset empties the pipeline and loads the register defaults:
// radius 1.0, quarter height 0.25, sine 0.7071, epsilon one LSB.
`include "cone_support_point_macros.svh"
module cone_support_point import csp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  vec_t                   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output point_t                 out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  logic        en;
  logic [28:0] bottom_radius;
  logic [28:0] quarter_height;
  logic [16:0] sin_angle;
  logic [15:0] epsilon;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bottom_radius  <= RESET_BOTTOM_RADIUS;
      quarter_height <= RESET_QUARTER_HEIGHT;
      sin_angle      <= RESET_SIN_ANGLE;
      epsilon        <= RESET_EPSILON;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOTTOM_RADIUS:  bottom_radius  <= cfg_data[28:0];
        REG_QUARTER_HEIGHT: quarter_height <= cfg_data[28:0];
        REG_SIN_ANGLE:      sin_angle      <= cfg_data[16:0];
        REG_EPSILON:        epsilon        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic v0;
  vec_t x0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= in_data;
    end
  end

  // Magnitudes, squares and rim numerators.
  logic [31:0] mag_x;
  logic [31:0] mag_y;
  logic [31:0] mag_z;
  logic [60:0] prod_x;
  logic [60:0] prod_z;

  assign mag_x  = x0.vec_x[31] ? 32'(-x0.vec_x) : 32'(x0.vec_x);
  assign mag_y  = x0.vec_y[31] ? 32'(-x0.vec_y) : 32'(x0.vec_y);
  assign mag_z  = x0.vec_z[31] ? 32'(-x0.vec_z) : 32'(x0.vec_z);
  assign prod_x = 61'(mag_x * bottom_radius);
  assign prod_z = 61'(mag_z * bottom_radius);

  logic        v1;
  logic [62:0] sqx1;
  logic [62:0] sqy1;
  logic [62:0] sqz1;
  csp_side_t   sd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx1      <= 63'(mag_x * mag_x);
      sqy1      <= 63'(mag_y * mag_y);
      sqz1      <= 63'(mag_z * mag_z);
      sd1.y     <= x0.vec_y;
      sd1.num_x <= prod_x[59:0];
      sd1.num_z <= prod_z[59:0];
      sd1.neg_x <= x0.vec_x[31];
      sd1.neg_z <= x0.vec_z[31];
    end
  end

  // Sums of squares.
  logic        v2;
  logic [63:0] nn2;
  logic [63:0] na2;
  csp_side_t   sd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nn2 <= {1'b0, sqx1} + {1'b0, sqy1} + {1'b0, sqz1};
      na2 <= {1'b0, sqx1} + {1'b0, sqz1};
      sd2 <= sd1;
    end
  end

  logic        vr;
  logic [31:0] norm;
  logic [31:0] axis;
  csp_side_t   sdr;

  csp_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .n_norm   (nn2),
    .n_axis   (na2),
    .side_in  (sd2),
    .out_valid(vr),
    .norm     (norm),
    .axis     (axis),
    .side_out (sdr)
  );

  // Cone test product and case flags.
  logic        v3;
  logic [48:0] rhs3;
  logic [31:0] s3;
  logic        nz3;
  logic        sok3;
  logic        ovx3;
  logic        ovz3;
  csp_side_t   sd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rhs3 <= 49'(norm * sin_angle);
      s3   <= axis;
      nz3  <= norm > {16'd0, epsilon};
      sok3 <= axis > {16'd0, epsilon};
      ovx3 <= {3'b000, sdr.num_x[59:31]} >= axis;
      ovz3 <= {3'b000, sdr.num_z[59:31]} >= axis;
      sd3  <= sdr;
    end
  end

  logic signed [63:0] lhs3;
  logic signed [63:0] rhs3_s;

  assign lhs3   = $signed({{32{sd3.y[31]}}, sd3.y}) <<< FRAC_BITS;
  assign rhs3_s = $signed({15'd0, rhs3});

  logic        v4;
  logic [31:0] s4;
  logic [59:0] numx4;
  logic [59:0] numz4;
  csp_flags_t  fl4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4        <= s3;
      numx4     <= sd3.num_x;
      numz4     <= sd3.num_z;
      fl4.nz    <= nz3;
      fl4.apex  <= lhs3 > rhs3_s;
      fl4.sok   <= sok3;
      fl4.ovx   <= ovx3;
      fl4.ovz   <= ovz3;
      fl4.neg_x <= sd3.neg_x;
      fl4.neg_z <= sd3.neg_z;
    end
  end

  logic        vd;
  logic [30:0] quo_x;
  logic [30:0] quo_z;
  csp_flags_t  fld;

  csp_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .s        (s4),
    .num_x    (numx4),
    .num_z    (numz4),
    .flags_in (fl4),
    .out_valid(vd),
    .quo_x    (quo_x),
    .quo_z    (quo_z),
    .flags_out(fld)
  );

  // Result selection and saturation.
  logic [30:0]        qh3;
  logic signed [31:0] neg_qh;
  logic signed [31:0] rim_x;
  logic signed [31:0] rim_z;
  point_t             point_next;

  assign qh3    = {2'b00, quarter_height} + {1'b0, quarter_height, 1'b0};
  assign neg_qh = -$signed({3'b000, quarter_height});

  always_comb begin
    if (fld.ovx) begin
      rim_x = fld.neg_x ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      rim_x = fld.neg_x ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
    end
    if (fld.ovz) begin
      rim_z = fld.neg_z ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      rim_z = fld.neg_z ? -$signed({1'b0, quo_z}) : $signed({1'b0, quo_z});
    end
  end

  always_comb begin
    point_next = '0;
    if (fld.nz) begin
      if (fld.apex) begin
        point_next.point_y = $signed({1'b0, qh3});
      end else begin
        point_next.point_y = neg_qh;
        if (fld.sok) begin
          point_next.point_x = rim_x;
          point_next.point_z = rim_z;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= point_next;
    end
  end

  `CSP_ASSERT_IMPL(a_rim_height, out_valid && (out_data.point_x != 32'sd0), out_data.point_y == neg_qh, "Rim point does not lie on the base plane.")
  `CSP_ASSERT_IMPL(a_apex_axis, out_valid && (out_data.point_y > 32'sd0), (out_data.point_x == 32'sd0) && (out_data.point_z == 32'sd0), "Apex result is off the axis.")
  `CSP_ASSERT_NOW(a_stall_blocks, !(out_valid && !out_ready && in_ready), "Input accepted while the output is stalled.")

endmodule
